@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/i2cps_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cps_pkg
// Shared types and constants of the I2C master phase sequencer.
// ----------------------------------------------------------------------------
package i2cps_pkg;

  // command codes (input kind)
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam int unsigned BIT_COUNT = 8;

  // start / stop phases
  localparam logic [4:0] PH_START_SDA_HI = 5'd1;
  localparam logic [4:0] PH_START_SDA_LO = 5'd2;
  localparam logic [4:0] PH_START_LAST   = 5'd3;
  localparam logic [4:0] PH_STOP_SCL_HI  = 5'd1;
  localparam logic [4:0] PH_STOP_LAST    = 5'd2;

  // write phases: 0 setup, 1..24 data bits, then ack release, ack sample, last
  localparam logic [4:0] PH_WR_LAST_BIT = 5'(3 * BIT_COUNT);
  localparam logic [4:0] PH_WR_ACK_REL  = 5'(3 * BIT_COUNT + 1);
  localparam logic [4:0] PH_WR_ACK_SMP  = 5'(3 * BIT_COUNT + 2);

  // read phases: 0 setup, 1 release SDA, 2..17 data bits, then ack handling
  localparam logic [4:0] PH_RD_SDA_REL  = 5'd1;
  localparam logic [4:0] PH_RD_LAST_BIT = 5'(1 + 2 * BIT_COUNT);
  localparam logic [4:0] PH_RD_ACK_SCL0 = 5'(2 + 2 * BIT_COUNT);
  localparam logic [4:0] PH_RD_ACK_SDA  = 5'(3 + 2 * BIT_COUNT);
  localparam logic [4:0] PH_RD_ACK_SCL1 = 5'(4 + 2 * BIT_COUNT);
  localparam logic [4:0] PH_RD_ACK_SCL2 = 5'(5 + 2 * BIT_COUNT);

  // sequencer state
  typedef struct packed {
    logic [4:0] phase;
    logic [2:0] cmd;
    logic [3:0] bits_left;
    logic [7:0] shift_data;
    logic       ack_req;
    logic       scl;
    logic       sda;
    logic [7:0] last_read;
    logic       nack;
  } i2cps_state_t;

endpackage

@@ sv/i2cps_phase.sv @@
// ----------------------------------------------------------------------------
// i2cps_phase
// Next-state logic for one pin phase: command capture and line updates.
// ----------------------------------------------------------------------------
module i2cps_phase
  import i2cps_pkg::*;
(
  input  i2cps_state_t st,
  input  logic [2:0]   kind,
  input  logic [7:0]   write_byte,
  input  logic         send_ack,
  input  logic         sda_sample,
  output i2cps_state_t st_nxt,
  output logic         done_nxt
);

  // slot within a write bit (SDA set, SCL high, SCL low) = (p - 1) mod 3
  function automatic logic [1:0] wr_slot(input logic [4:0] p);
    logic [1:0] q;
    case (p)
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22: q = 2'd0;
      5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20, 5'd23: q = 2'd1;
      default:                                            q = 2'd2;
    endcase
    return q;
  endfunction

  always_comb begin
    i2cps_state_t s;
    logic         done;
    logic [4:0]   p;
    s    = st;
    done = 1'b0;

    // new command only while idle; unknown kinds act as step only
    if (st.cmd == CMD_NONE && kind inside {[CMD_START:CMD_READ]}) begin
      s.cmd     = kind;
      s.ack_req = send_ack;
      s.phase   = '0;
    end
    p = s.phase;

    if (s.cmd != CMD_NONE) begin
      case (s.cmd)
        CMD_START: begin
          if (p == '0) begin
            s.scl = 1'b1;
          end else if (p == PH_START_SDA_HI) begin
            s.sda = 1'b1;
          end else if (p == PH_START_SDA_LO) begin
            s.sda = 1'b0;
          end else begin
            s.scl = 1'b0;
            done  = 1'b1;
          end
        end
        CMD_STOP: begin
          if (p == '0) begin
            s.sda = 1'b0;
          end else if (p == PH_STOP_SCL_HI) begin
            s.scl = 1'b1;
          end else begin
            s.sda = 1'b1;
            done  = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (p == '0) begin
            s.scl        = 1'b0;
            s.shift_data = write_byte;
            s.bits_left  = 4'(BIT_COUNT);
          end else if (p <= PH_WR_LAST_BIT) begin
            case (wr_slot(p))
              2'd0: s.sda = s.shift_data[7];
              2'd1: s.scl = 1'b1;
              default: begin
                s.scl        = 1'b0;
                s.shift_data = {s.shift_data[6:0], 1'b0};
                s.bits_left  = s.bits_left - 4'd1;
              end
            endcase
          end else if (p == PH_WR_ACK_REL) begin
            s.sda = 1'b1;
          end else if (p == PH_WR_ACK_SMP) begin
            s.scl  = 1'b1;
            s.nack = sda_sample;
          end else begin
            s.scl = 1'b0;
            done  = 1'b1;
          end
        end
        default: begin
          // read
          if (p == '0) begin
            s.scl        = 1'b0;
            s.shift_data = '0;
            s.bits_left  = 4'(BIT_COUNT);
          end else if (p == PH_RD_SDA_REL) begin
            s.sda = 1'b1;
          end else if (p <= PH_RD_LAST_BIT) begin
            if (!p[0]) begin
              // SCL rising edge: sample this phase's SDA
              s.shift_data = {s.shift_data[6:0], sda_sample};
              s.scl        = 1'b1;
            end else begin
              s.scl = 1'b0;
              if (s.bits_left == 4'd1) begin
                s.last_read = s.shift_data;
              end
              s.bits_left = s.bits_left - 4'd1;
            end
          end else if (p == PH_RD_ACK_SCL0) begin
            s.scl = 1'b0;
          end else if (p == PH_RD_ACK_SDA) begin
            s.sda = ~s.ack_req;
          end else if (p == PH_RD_ACK_SCL1) begin
            s.scl = 1'b1;
          end else if (p == PH_RD_ACK_SCL2) begin
            s.scl = 1'b0;
            done  = ~s.ack_req;
          end else begin
            // release SDA after an ACK
            s.sda = 1'b1;
            done  = 1'b1;
          end
        end
      endcase

      if (done) begin
        s.cmd   = CMD_NONE;
        s.phase = '0;
      end else begin
        s.phase = p + 5'd1;
      end
    end

    st_nxt   = s;
    done_nxt = done;
  end

endmodule

@@ sv/i2c_master_phase_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// i2c_master_phase_sequencer_top
// Bit-bang I2C master: one SCL/SDA phase per input beat (start, stop,
// byte write, byte read with ACK/NACK).
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+--------------------------------
//   in_     | input     | in_valid/in_stall| kind, write_byte, send_ack,
//           |           |                  | sda_sample
//   out_    | output    | out_valid/       | scl_level, sda_level, busy_res,
//           |           | out_stall        | done_res, read_byte, no_ack
//
// One input beat per cycle unless stalled; its result appears in the cycle
// after it is accepted. State and result share one register stage fed by
// the phase logic. in_stall rises only while a result waits on out_stall.
// Synchronous active-low reset: lines released high, sequencer idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_phase_sequencer_top
  import i2cps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_kind,
  input  logic [7:0] in_write_byte,
  input  logic       in_send_ack,
  input  logic       in_sda_sample,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_read_byte,
  output logic       out_no_ack
);

  i2cps_state_t state_r, state_nxt;
  logic         done_r, done_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         in_accept;

  // accept when the result slot is free or drains this cycle
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // phase decode
  i2cps_phase u_phase (
    .st         (state_r),
    .kind       (in_kind),
    .write_byte (in_write_byte),
    .send_ack   (in_send_ack),
    .sda_sample (in_sda_sample),
    .st_nxt     (state_nxt),
    .done_nxt   (done_nxt)
  );

  // result valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // state and result registers; state only moves on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= '0;
      state_r.cmd        <= CMD_NONE;
      state_r.bits_left  <= '0;
      state_r.shift_data <= '0;
      state_r.ack_req    <= 1'b0;
      state_r.scl        <= 1'b1;
      state_r.sda        <= 1'b1;
      state_r.last_read  <= '0;
      state_r.nack       <= 1'b0;
      done_r             <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        state_r <= state_nxt;
        done_r  <= done_nxt;
      end
    end
  end

  // result beat comes straight from the state after the phase
  assign out_valid     = out_valid_r;
  assign out_scl_level = state_r.scl;
  assign out_sda_level = state_r.sda;
  assign out_busy_res  = (state_r.cmd != CMD_NONE);
  assign out_done_res  = done_r;
  assign out_read_byte = state_r.last_read;
  assign out_no_ack    = state_r.nack;

  // checks
  `ASSERT_NEXT(a_accept_gives_beat, clk, rst_n, in_accept, out_valid_r,
               "accepted beat produced no result")
  `ASSERT_IMPLY(a_done_ends_cmd, clk, rst_n, done_r, state_r.cmd == CMD_NONE,
                "done pulse while a command is still active")
  `ASSERT_IMPLY(a_idle_phase_zero, clk, rst_n, state_r.cmd == CMD_NONE,
                state_r.phase == '0, "phase counter not cleared while idle")
  `ASSERT_IMPLY(a_start_len, clk, rst_n, state_r.cmd == CMD_START,
                state_r.phase < 5'd4, "start sequence overran")
  `ASSERT_IMPLY(a_stall_only_full, clk, rst_n, in_stall, out_valid_r,
                "input stalled with empty result slot")

endmodule
